### sv/msl_pkg.sv
// ----------------------------------------------------------------------------
// msl_pkg
// Shared widths, constants and register codes of the 2D mean shift labeler.
// ----------------------------------------------------------------------------
package msl_pkg;

  localparam int MaxPointsDef = 64;
  localparam int CoordW       = 24;
  localparam int DiffW        = CoordW + 1;
  localparam int SqW          = 2 * DiffW - 1;
  localparam int DsqW         = SqW + 1;
  localparam int SumW         = CoordW + 7;
  localparam int MembW        = 7;
  localparam int LabW         = 6;
  localparam int BwW          = 20;
  localparam int Bw2W         = 2 * BwW;
  localparam int IterW        = 8;
  localparam int BaseW        = 16;
  localparam int LabelW       = 18;
  localparam int CfgIdxW      = 3;
  localparam int CfgDataW     = 20;
  localparam int ConvLim      = 16;

  localparam logic [LabelW-1:0] NoiseLabel = 18'h3FFFE;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBandwidth = 3'd0,
    CfgMaxIter   = 3'd1,
    CfgMinPoints = 3'd2,
    CfgBaseLabel = 3'd3
  } cfg_idx_e;

endpackage

### sv/msl_dist.sv
// ----------------------------------------------------------------------------
// msl_dist
// Two-stage squared distance unit: difference, then squares, summed at output.
// ----------------------------------------------------------------------------
module msl_dist (
  input  logic                       clk_i,
  input  msl_pkg::coord_t            ax_i,
  input  msl_pkg::coord_t            ay_i,
  input  msl_pkg::coord_t            bx_i,
  input  msl_pkg::coord_t            by_i,
  output logic [msl_pkg::DsqW-1:0]   dsq_o
);
  import msl_pkg::*;

  logic signed [DiffW-1:0]   dx_q, dy_q;
  logic signed [2*DiffW-1:0] px, py;
  logic [SqW-1:0]            sqx_q, sqy_q;

  assign px = dx_q * dx_q;
  assign py = dy_q * dy_q;

  always_ff @(posedge clk_i) begin
    dx_q  <= DiffW'(ax_i) - DiffW'(bx_i);
    dy_q  <= DiffW'(ay_i) - DiffW'(by_i);
    sqx_q <= px[SqW-1:0];
    sqy_q <= py[SqW-1:0];
  end

  assign dsq_o = DsqW'(sqx_q) + DsqW'(sqy_q);

endmodule

### sv/msl_div.sv
// ----------------------------------------------------------------------------
// msl_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module msl_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [msl_pkg::SumW-1:0]   dividend_i,
  input  logic [msl_pkg::MembW-1:0]  divisor_i,
  output logic                       done_o,
  output logic [msl_pkg::SumW-1:0]   quot_o
);
  import msl_pkg::*;

  localparam int StepW = $clog2(SumW + 1);

  logic             run_q, done_q;
  logic [StepW-1:0] step_q;
  logic [MembW:0]   rem_q, rem_sh;
  logic [MembW-1:0] div_q;
  logic [SumW-1:0]  quo_q;
  logic             ge;

  assign rem_sh = {rem_q[MembW-1:0], quo_q[SumW-1]};
  assign ge     = rem_sh >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == StepW'(SumW - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      div_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (run_q) begin
      rem_q <= ge ? rem_sh - {1'b0, div_q} : rem_sh;
      quo_q <= {quo_q[SumW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

### sv/mean_shift_2d_cluster_labeler_core.sv
// ----------------------------------------------------------------------------
// mean_shift_2d_cluster_labeler_core
// Flat-kernel 2D mean shift clustering with per-point label output.
// ----------------------------------------------------------------------------
// Points enter on start/x_coord_i/y_coord_i/last_i, one request per cycle
// while busy is low. Points beyond MAX_POINTS are dropped and set
// overflow_o for the whole set.
// A request with last_i high closes the set; busy then stays high while the
// block places every point. Per point and mean shift round: a neighbour scan
// over the point memory (one read per cycle), two serial divisions on the
// shared divider, and a shift test. Per point, a mode merge scan over the mode
// memory, plus load, setup and write back.
// Results follow: one label per point, each on the result ports for one
// cycle marked by result_valid_o; the receiver cannot stall.
// The configuration channel is always ready; write it only while idle.
// Reset clears counts and flags and restores the register defaults; no
// memory clearing is needed.
// ----------------------------------------------------------------------------
module mean_shift_2d_cluster_labeler_core #(
  parameter int MAX_POINTS = msl_pkg::MaxPointsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  msl_pkg::coord_t               x_coord_i,
  input  msl_pkg::coord_t               y_coord_i,
  input  logic                          last_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [msl_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [msl_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic                          result_valid_o,
  output logic [msl_pkg::LabW-1:0]      point_index_o,
  output logic signed [msl_pkg::LabelW-1:0] label_o,
  output logic                          last_result_o,
  output logic                          overflow_o
);
  import msl_pkg::*;

  localparam int IdxW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CntW  = $clog2(MAX_POINTS + 1);
  localparam int PtW   = LabW + 2 * CoordW;
  localparam int ModeW = MembW + 2 * CoordW;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PLOAD, ST_PWAIT, ST_SINIT, ST_SCAN, ST_DIVX, ST_DIVY,
    ST_CONV0, ST_CONV1, ST_CONV2, ST_MINIT, ST_MSCAN, ST_MEND,
    ST_ORD, ST_ORD2, ST_OEMIT
  } state_e;

  // configuration
  logic [BwW-1:0]   bw_q;
  logic [Bw2W-1:0]  bw2_q;
  logic [IterW-1:0] max_iter_q;
  logic [MembW-1:0] min_pts_q;
  logic [BaseW-1:0] base_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bw_q       <= BwW'(2048);
      max_iter_q <= IterW'(50);
      min_pts_q  <= MembW'(1);
      base_q     <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgBandwidth: bw_q       <= cfg_data_i[BwW-1:0];
        CfgMaxIter:   max_iter_q <= cfg_data_i[IterW-1:0];
        CfgMinPoints: min_pts_q  <= cfg_data_i[MembW-1:0];
        CfgBaseLabel: base_q     <= cfg_data_i[BaseW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    bw2_q <= bw_q * bw_q;
  end

  // memories
  logic [PtW-1:0]   pt_mem [MAX_POINTS];
  logic [ModeW-1:0] md_mem [MAX_POINTS];
  logic [PtW-1:0]   pt_rd_q, pt_wdata;
  logic [ModeW-1:0] md_rd_q, md_wdata;
  logic             pt_we, md_we;
  logic [IdxW-1:0]  pt_waddr, pt_raddr, md_waddr, md_raddr;

  always_ff @(posedge clk_i) begin
    if (pt_we) pt_mem[pt_waddr] <= pt_wdata;
    pt_rd_q <= pt_mem[pt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (md_we) md_mem[md_waddr] <= md_wdata;
    md_rd_q <= md_mem[md_raddr];
  end

  // control and datapath registers
  state_e            state_q;
  logic [CntW-1:0]   pt_cnt_q, md_cnt_q, i_q, j_q, k_q, n_q;
  logic              ovf_q;
  logic [IterW-1:0]  it_q;
  coord_t            cx_q, cy_q, px_q, py_q, nx_q, ny_q;
  logic signed [SumW-1:0] sx_q, sy_q;
  logic              div_run_q;
  logic              rv_q, ln1_v_q, ln2_v_q;
  logic [IdxW-1:0]   rtag_q, ln1_tag_q, ln2_tag_q;
  coord_t            ln1_x_q, ln1_y_q, ln2_x_q, ln2_y_q;
  logic [MembW-1:0]  ln1_m_q, ln2_m_q;
  logic              found_q;
  logic [IdxW-1:0]   fidx_q, lab_q;
  coord_t            fx_q, fy_q, lx_q, ly_q;
  logic [MembW-1:0]  fm_q, lm_q;
  logic              res_v_q, res_last_q;
  logic [LabW-1:0]   res_idx_q;
  logic [LabelW-1:0] res_lab_q;

  // combinational
  logic              accept, issue, drained;
  logic [CntW-1:0]   lim;
  coord_t            src_x, src_y, ax, ay;
  logic [MembW-1:0]  src_m;
  logic [DsqW-1:0]   dsq;
  logic              div_start, div_done;
  logic [SumW-1:0]   div_dvd, div_quo, mag;
  logic signed [SumW-1:0] sel_sum;
  logic [IdxW-1:0]   new_lab;
  logic [MembW-1:0]  emit_memb;

  assign busy    = (state_q != ST_IDLE) | res_v_q;
  assign accept  = start & ~busy;
  assign lim     = (state_q == ST_MSCAN) ? md_cnt_q : pt_cnt_q;
  assign issue   = ((state_q == ST_SCAN) || (state_q == ST_MSCAN)) && (j_q < lim);
  assign drained = (j_q == lim) & ~rv_q & ~ln1_v_q & ~ln2_v_q;

  assign src_x = (state_q == ST_MSCAN) ? coord_t'(md_rd_q[2*CoordW-1:CoordW])
                                       : coord_t'(pt_rd_q[2*CoordW-1:CoordW]);
  assign src_y = (state_q == ST_MSCAN) ? coord_t'(md_rd_q[CoordW-1:0])
                                       : coord_t'(pt_rd_q[CoordW-1:0]);
  assign src_m = md_rd_q[ModeW-1 -: MembW];
  assign ax    = (state_q == ST_CONV0) ? nx_q : src_x;
  assign ay    = (state_q == ST_CONV0) ? ny_q : src_y;

  msl_dist u_dist (
    .clk_i (clk_i),
    .ax_i  (ax),
    .ay_i  (ay),
    .bx_i  (cx_q),
    .by_i  (cy_q),
    .dsq_o (dsq)
  );

  assign sel_sum   = (state_q == ST_DIVY) ? sy_q : sx_q;
  assign mag       = sel_sum[SumW-1] ? SumW'(-sel_sum) : SumW'(sel_sum);
  assign div_dvd   = mag + SumW'(n_q >> 1);
  assign div_start = ((state_q == ST_DIVX) || (state_q == ST_DIVY)) && !div_run_q;

  msl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (MembW'(n_q)),
    .done_o     (div_done),
    .quot_o     (div_quo)
  );

  assign emit_memb = md_rd_q[ModeW-1 -: MembW];

  always_comb begin
    new_lab = IdxW'(MAX_POINTS - 1);
    md_we    = 1'b0;
    md_waddr = IdxW'(MAX_POINTS - 1);
    md_wdata = {lm_q + 1'b1, lx_q, ly_q};
    if (state_q == ST_MEND) begin
      md_we = 1'b1;
      if (found_q) begin
        new_lab  = fidx_q;
        md_waddr = fidx_q;
        md_wdata = {fm_q + 1'b1, fx_q, fy_q};
      end else if (md_cnt_q < CntW'(MAX_POINTS)) begin
        new_lab  = md_cnt_q[IdxW-1:0];
        md_waddr = md_cnt_q[IdxW-1:0];
        md_wdata = {MembW'(1), cx_q, cy_q};
      end
    end
  end

  always_comb begin
    pt_we    = 1'b0;
    pt_waddr = pt_cnt_q[IdxW-1:0];
    pt_wdata = {LabW'(0), x_coord_i, y_coord_i};
    if (accept && (pt_cnt_q < CntW'(MAX_POINTS))) begin
      pt_we = 1'b1;
    end else if (state_q == ST_MEND) begin
      pt_we    = 1'b1;
      pt_waddr = i_q[IdxW-1:0];
      pt_wdata = {LabW'(new_lab), px_q, py_q};
    end
  end

  always_comb begin
    unique case (state_q)
      ST_PLOAD: pt_raddr = i_q[IdxW-1:0];
      ST_ORD:   pt_raddr = k_q[IdxW-1:0];
      default:  pt_raddr = j_q[IdxW-1:0];
    endcase
    md_raddr = (state_q == ST_ORD2) ? pt_rd_q[PtW-LabW +: IdxW]
                                    : j_q[IdxW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pt_cnt_q   <= '0;
      md_cnt_q   <= '0;
      ovf_q      <= 1'b0;
      div_run_q  <= 1'b0;
      rv_q       <= 1'b0;
      ln1_v_q    <= 1'b0;
      ln2_v_q    <= 1'b0;
      found_q    <= 1'b0;
      res_v_q    <= 1'b0;
      res_last_q <= 1'b0;
      i_q        <= '0;
      j_q        <= '0;
      k_q        <= '0;
      n_q        <= '0;
      it_q       <= '0;
    end else begin
      res_v_q   <= 1'b0;
      rv_q      <= issue;
      rtag_q    <= j_q[IdxW-1:0];
      ln1_v_q   <= rv_q;
      ln1_tag_q <= rtag_q;
      ln1_x_q   <= src_x;
      ln1_y_q   <= src_y;
      ln1_m_q   <= src_m;
      ln2_v_q   <= ln1_v_q;
      ln2_tag_q <= ln1_tag_q;
      ln2_x_q   <= ln1_x_q;
      ln2_y_q   <= ln1_y_q;
      ln2_m_q   <= ln1_m_q;
      if (issue) j_q <= j_q + 1'b1;

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (pt_cnt_q < CntW'(MAX_POINTS)) pt_cnt_q <= pt_cnt_q + 1'b1;
            else ovf_q <= 1'b1;
            if (last_i) begin
              i_q      <= '0;
              md_cnt_q <= '0;
              state_q  <= ST_PLOAD;
            end
          end
        end
        ST_PLOAD: state_q <= ST_PWAIT;
        ST_PWAIT: begin
          cx_q <= coord_t'(pt_rd_q[2*CoordW-1:CoordW]);
          cy_q <= coord_t'(pt_rd_q[CoordW-1:0]);
          px_q <= coord_t'(pt_rd_q[2*CoordW-1:CoordW]);
          py_q <= coord_t'(pt_rd_q[CoordW-1:0]);
          it_q <= '0;
          state_q <= (max_iter_q == '0) ? ST_MINIT : ST_SINIT;
        end
        ST_SINIT: begin
          sx_q    <= '0;
          sy_q    <= '0;
          n_q     <= '0;
          j_q     <= '0;
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (ln2_v_q && (dsq < DsqW'(bw2_q))) begin
            sx_q <= sx_q + SumW'(ln2_x_q);
            sy_q <= sy_q + SumW'(ln2_y_q);
            n_q  <= n_q + 1'b1;
          end
          if (drained) state_q <= (n_q == '0) ? ST_MINIT : ST_DIVX;
        end
        ST_DIVX: begin
          if (!div_run_q) begin
            div_run_q <= 1'b1;
          end else if (div_done) begin
            div_run_q <= 1'b0;
            nx_q      <= sx_q[SumW-1] ? CoordW'(-div_quo) : CoordW'(div_quo);
            state_q   <= ST_DIVY;
          end
        end
        ST_DIVY: begin
          if (!div_run_q) begin
            div_run_q <= 1'b1;
          end else if (div_done) begin
            div_run_q <= 1'b0;
            ny_q      <= sy_q[SumW-1] ? CoordW'(-div_quo) : CoordW'(div_quo);
            state_q   <= ST_CONV0;
          end
        end
        ST_CONV0: state_q <= ST_CONV1;
        ST_CONV1: state_q <= ST_CONV2;
        ST_CONV2: begin
          cx_q <= nx_q;
          cy_q <= ny_q;
          it_q <= it_q + 1'b1;
          if ((dsq <= DsqW'(ConvLim)) || ((it_q + 1'b1) == max_iter_q)) begin
            state_q <= ST_MINIT;
          end else begin
            state_q <= ST_SINIT;
          end
        end
        ST_MINIT: begin
          j_q     <= '0;
          found_q <= 1'b0;
          state_q <= ST_MSCAN;
        end
        ST_MSCAN: begin
          if (ln2_v_q) begin
            if (!found_q && ({dsq, 2'b00} < (DsqW + 2)'(bw2_q))) begin
              found_q <= 1'b1;
              fidx_q  <= ln2_tag_q;
              fx_q    <= ln2_x_q;
              fy_q    <= ln2_y_q;
              fm_q    <= ln2_m_q;
            end
            if (ln2_tag_q == IdxW'(MAX_POINTS - 1)) begin
              lx_q <= ln2_x_q;
              ly_q <= ln2_y_q;
              lm_q <= ln2_m_q;
            end
          end
          if (drained) state_q <= ST_MEND;
        end
        ST_MEND: begin
          if (!found_q && (md_cnt_q < CntW'(MAX_POINTS))) md_cnt_q <= md_cnt_q + 1'b1;
          i_q <= i_q + 1'b1;
          if ((i_q + 1'b1) == pt_cnt_q) begin
            k_q     <= '0;
            state_q <= ST_ORD;
          end else begin
            state_q <= ST_PLOAD;
          end
        end
        ST_ORD:  state_q <= ST_ORD2;
        ST_ORD2: begin
          lab_q   <= md_raddr;
          state_q <= ST_OEMIT;
        end
        ST_OEMIT: begin
          res_v_q    <= 1'b1;
          res_idx_q  <= LabW'(k_q);
          res_last_q <= (k_q + 1'b1) == pt_cnt_q;
          res_lab_q  <= (emit_memb < min_pts_q) ? NoiseLabel
                                                : LabelW'(base_q) + LabelW'(lab_q);
          k_q <= k_q + 1'b1;
          if ((k_q + 1'b1) == pt_cnt_q) begin
            pt_cnt_q <= '0;
            state_q  <= ST_IDLE;
          end else begin
            state_q <= ST_ORD;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      if (res_v_q && res_last_q) ovf_q <= 1'b0;
    end
  end

  assign result_valid_o = res_v_q;
  assign point_index_o  = res_idx_q;
  assign label_o        = res_lab_q;
  assign last_result_o  = res_last_q;
  assign overflow_o     = ovf_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pt_cnt_q <= CntW'(MAX_POINTS)) && (md_cnt_q <= CntW'(MAX_POINTS)))
    else $error("point or mode count beyond capacity");

  a_pipe_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ln2_v_q |-> $past(ln1_v_q))
    else $error("scan pipeline valid skipped a stage");

  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIVX || state_q == ST_DIVY))
    else $error("divider finished outside a division state");

  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == ST_OEMIT))
    else $error("result strobe without emit state");

endmodule

### tb/sv/msl_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// msl_checker
// Watches the point, configuration and label channels of the mean shift
// labeler, predicts the label of every stored point of each closed set and
// compares each label strobe against the oldest predicted one.
// ----------------------------------------------------------------------------
module msl_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              busy_i,
  input  msl_pkg::coord_t                   x_coord_i,
  input  msl_pkg::coord_t                   y_coord_i,
  input  logic                              last_i,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [msl_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [msl_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                              result_valid_i,
  input  logic [msl_pkg::LabW-1:0]          point_index_i,
  input  logic signed [msl_pkg::LabelW-1:0] label_i,
  input  logic                              last_result_i,
  input  logic                              overflow_i,
  output int                                errors_o,
  output int                                pending_o
);
  import msl_pkg::*;

  localparam int Cap   = MaxPointsDef;
  localparam int Slots = 2 * Cap;

  typedef struct packed {
    logic [LabW-1:0]   index;
    logic [LabelW-1:0] label;
    logic              last;
    logic              ovf;
  } label_t;

  label_t       label_mem[Slots];
  int           wr_cnt = 0;
  int           rd_cnt = 0;
  int           err_cnt = 0;
  longint       bandwidth, max_iter, min_points, base_label;
  longint       pts_x[Cap], pts_y[Cap], mode_x[Cap], mode_y[Cap];
  int           pt_cnt, mode_cnt;
  int           pt_mode[Cap], members[Cap];
  bit           ovf_flag;

  assign pending_o = wr_cnt - rd_cnt;
  assign errors_o  = err_cnt;

  function automatic longint dist_sq(longint ax, longint ay, longint bx, longint by);
    return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
  endfunction

  function automatic longint round_div(longint s, longint n);
    longint mag, q;
    mag = (s < 0) ? -s : s;
    q = (mag + n / 2) / n;
    return (s < 0) ? -q : q;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("msl_checker: %s mismatch got %0d want %0d at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  task automatic place(input int i);
    longint bw2, cx, cy, sx, sy, n, nx, ny;
    int     found;
    bit     conv;
    bw2 = bandwidth * bandwidth;
    cx = pts_x[i];
    cy = pts_y[i];
    for (longint it = 0; it < max_iter; it++) begin
      sx = 0; sy = 0; n = 0;
      for (int j = 0; j < pt_cnt; j++) begin
        if (dist_sq(pts_x[j], pts_y[j], cx, cy) < bw2) begin
          sx += pts_x[j];
          sy += pts_y[j];
          n++;
        end
      end
      if (n == 0) break;
      nx = round_div(sx, n);
      ny = round_div(sy, n);
      conv = dist_sq(nx, ny, cx, cy) <= ConvLim;
      cx = nx;
      cy = ny;
      if (conv) break;
    end
    found = mode_cnt;
    for (int m = 0; m < mode_cnt; m++) begin
      if (4 * dist_sq(mode_x[m], mode_y[m], cx, cy) < bw2) begin
        found = m;
        break;
      end
    end
    if (found == mode_cnt && mode_cnt < Cap) begin
      mode_x[mode_cnt] = cx;
      mode_y[mode_cnt] = cy;
      members[mode_cnt] = 0;
      mode_cnt++;
    end
    if (found >= Cap) found = Cap - 1;
    pt_mode[i] = found;
    members[found]++;
  endtask

  task automatic label_set();
    label_t r;
    mode_cnt = 0;
    foreach (members[m]) members[m] = 0;
    for (int i = 0; i < pt_cnt; i++) place(i);
    for (int i = 0; i < pt_cnt; i++) begin
      r.index = i[LabW-1:0];
      if (members[pt_mode[i]] < min_points) r.label = NoiseLabel;
      else r.label = LabelW'(base_label + pt_mode[i]);
      r.last = (i + 1 == pt_cnt);
      r.ovf = ovf_flag;
      label_mem[wr_cnt % Slots] = r;
      wr_cnt++;
    end
    pt_cnt = 0;
    mode_cnt = 0;
    ovf_flag = 0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    label_t w;
    if (!rst_ni) begin
      bandwidth = 2048;
      max_iter = 50;
      min_points = 1;
      base_label = 0;
      pt_cnt = 0;
      mode_cnt = 0;
      ovf_flag = 0;
      wr_cnt = 0;
      rd_cnt = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgBandwidth: bandwidth = cfg_data_i[BwW-1:0];
          CfgMaxIter:   max_iter = cfg_data_i[IterW-1:0];
          CfgMinPoints: min_points = cfg_data_i[MembW-1:0];
          CfgBaseLabel: base_label = cfg_data_i[BaseW-1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        if (pt_cnt < Cap) begin
          pts_x[pt_cnt] = longint'(x_coord_i);
          pts_y[pt_cnt] = longint'(y_coord_i);
          pt_cnt++;
        end else begin
          ovf_flag = 1;
        end
        if (last_i) label_set();
      end
      if (result_valid_i) begin
        if (wr_cnt == rd_cnt) begin
          report("unexpected label", label_i, 0);
        end else begin
          w = label_mem[rd_cnt % Slots];
          rd_cnt++;
          if (point_index_i !== w.index) report("point_index", point_index_i, w.index);
          if (label_i !== w.label) report("label", label_i, $signed(w.label));
          if (last_result_i !== w.last) report("last_result", last_result_i, w.last);
          if (overflow_i !== w.ovf) report("overflow", overflow_i, w.ovf);
        end
      end
    end
  end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the mean shift labeler: directed sets at field and
// register extremes, then random clustered point sets with random register
// settings, random gaps and one set beyond capacity.
// ----------------------------------------------------------------------------
module tb_top;
  import msl_pkg::*;

  localparam longint Limit = 40_000_000;

  logic                  clk_i, rst_ni;
  logic                  start, busy;
  coord_t                x_coord, y_coord;
  logic                  last;
  logic                  cfg_valid, cfg_ready;
  logic [CfgIdxW-1:0]    cfg_index;
  logic [CfgDataW-1:0]   cfg_data;
  logic                  result_valid;
  logic [LabW-1:0]       point_index;
  logic signed [LabelW-1:0] label;
  logic                  last_result, overflow;
  int                    errors, pending, items;
  longint                cycles = 0;

  mean_shift_2d_cluster_labeler_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .x_coord_i(x_coord), .y_coord_i(y_coord), .last_i(last),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data), .result_valid_o(result_valid),
    .point_index_o(point_index), .label_o(label), .last_result_o(last_result),
    .overflow_o(overflow)
  );

  msl_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start), .busy_i(busy),
    .x_coord_i(x_coord), .y_coord_i(y_coord), .last_i(last),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data), .result_valid_i(result_valid),
    .point_index_i(point_index), .label_i(label), .last_result_i(last_result),
    .overflow_i(overflow), .errors_o(errors), .pending_o(pending)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == Limit) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  task automatic send_point(input int x, input int y, input bit is_last);
    int g;
    start <= 1'b1;
    x_coord <= coord_t'(x);
    y_coord <= coord_t'(y);
    last <= is_last;
    do @(posedge clk_i); while (busy);
    items++;
    g = gap_len();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0 || busy);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CfgDataW'(value);
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  task automatic write_all(input int bw, input int it, input int mp, input int base);
    write_reg(CfgBandwidth, bw);
    write_reg(CfgMaxIter, it);
    write_reg(CfgMinPoints, mp);
    write_reg(CfgBaseLabel, base);
    cfg_valid <= 1'b0;
  endtask

  // clustered set: random centers, small offsets, some stray points
  task automatic send_set(input int size, input int spread);
    int cx[3], cy[3], k, ncl;
    ncl = $urandom_range(3, 1);
    for (int c = 0; c < 3; c++) begin
      cx[c] = $urandom;
      cy[c] = $urandom;
    end
    for (int i = 0; i < size; i++) begin
      k = $urandom_range(ncl - 1);
      if ($urandom_range(9) < 2)
        send_point($urandom, $urandom, i == size - 1);
      else
        send_point(cx[k] + $urandom_range(2 * spread) - spread,
                   cy[k] + $urandom_range(2 * spread) - spread, i == size - 1);
    end
  endtask

  initial begin
    int bw, sz;
    items = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    x_coord = '0;
    y_coord = '0;
    last = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_point(-8388608, 8388607, 1);
    send_point(8388607, -8388608, 0);
    send_point(0, 0, 0);
    send_point(100, 100, 1);
    wait_idle();
    write_all(0, 50, 1, 0);
    send_point(5, 5, 0);
    send_point(5, 5, 1);
    wait_idle();
    write_all(1048575, 0, 64, 65535);
    send_point(-8388608, -8388608, 0);
    send_point(8388607, 8388607, 0);
    send_point(0, 0, 1);
    wait_idle();
    write_all(1, 255, 0, 7);
    send_point(3, 3, 0);
    send_point(3, 4, 1);
    wait_idle();
    write_all(4096, 50, 2, 1234);
    send_point(0, 0, 0);
    send_point(1000, 0, 0);
    send_point(0, 1000, 0);
    send_point(80000, 80000, 0);
    send_point(81000, 80000, 0);
    send_point(-80000, 5, 1);

    // one set beyond capacity
    wait_idle();
    write_all(3000, 6, 3, $urandom_range(65535));
    send_set(66, 3000);

    while (items < 140) begin
      if ($urandom_range(3) == 0) begin
        wait_idle();
        bw = ($urandom_range(9) == 0) ? $urandom_range(1048575) : $urandom_range(8000, 300);
        write_all(bw, ($urandom_range(9) == 0) ? 255 : $urandom_range(60, 1),
                  ($urandom_range(5) == 0) ? $urandom_range(64) : $urandom_range(4),
                  $urandom_range(65535));
      end
      sz = ($urandom_range(9) == 0) ? $urandom_range(16, 9) : $urandom_range(8, 1);
      send_set(sz, $urandom_range(3000, 10));
    end

    wait_idle();
    repeat (50) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
